>>> hw/rtl/wpid_pkg.sv
// wpid_pkg: shared types, widths, register indexes and lane helpers
// for the three-axis windowed-integral PID block.
// No dependencies.
package wpid_pkg;

	// item and lane widths
	localparam int AXES       = 3;
	localparam int DATA_W     = 32;
	localparam int GAIN_W     = 16;
	localparam int CFG_W      = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int WINDOW_DEF = 10;

	// clamp magnitude is a Q8.8 lane moved up to Q16.16
	localparam int LIM_W   = GAIN_W + 8;
	localparam int INTEG_W = LIM_W + 1;

	// product widths and the Q26.24 accumulator
	localparam int PROD_W  = GAIN_W + DATA_W;
	localparam int PRODI_W = GAIN_W + INTEG_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int RND_W   = ACC_W - 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd3;

	// 1.0 in every lane
	localparam logic [CFG_W-1:0] LIMIT_RESET = 48'h0100_0100_0100;

	typedef struct packed {
		logic signed [DATA_W-1:0] target_x;
		logic signed [DATA_W-1:0] target_y;
		logic signed [DATA_W-1:0] target_z;
		logic signed [DATA_W-1:0] meas_x;
		logic signed [DATA_W-1:0] meas_y;
		logic signed [DATA_W-1:0] meas_z;
		logic signed [DATA_W-1:0] speed_x;
		logic signed [DATA_W-1:0] speed_y;
		logic signed [DATA_W-1:0] speed_z;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive_x;
		logic signed [DATA_W-1:0] drive_y;
		logic signed [DATA_W-1:0] drive_z;
		logic [AXES-1:0]          clipped;
	} result_t;

	// per-axis operands handed from the window stage to the multipliers
	typedef struct packed {
		logic signed [DATA_W-1:0]  err;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DATA_W-1:0]  vel;
	} axis_term_t;

	// one 16-bit lane of a packed register, x lowest
	function automatic logic [GAIN_W-1:0] lane(input logic [CFG_W-1:0] r, input int axis);
		lane = r[axis*GAIN_W +: GAIN_W];
	endfunction

endpackage

>>> hw/rtl/windowed_integral_pid_3axis.sv
// windowed_integral_pid_3axis: top level of the three-axis PID controller.
// Depends on wpid_pkg, wpid_window and wpid_axis_mac.
//
// Usage:
//  - sample channel (sample_valid/sample_ready/sample) takes target, measured
//    position and measured velocity for x, y, z in signed Q16.16.
//  - result channel (result_valid/result_ready/result) returns one item per
//    sample: drive_x/y/z in signed Q16.16 and the per-axis clipped flags.
//  - cfg_we/cfg_index/cfg_data write the gain and limit registers; write
//    them only while no items are in flight.
//  - from the accepting edge, the item moves from the input register through
//    the window stage register and the product registers into the result
//    register, which sets result_valid. Throughput is one item per cycle
//    while results are taken; the running window sums update once per item
//    in the window stage by subtract-oldest, add-newest.
//  - when the receiver stalls, the result register holds its item and the
//    stages behind it keep filling; sample_ready drops only when all four
//    stages hold an item.
//  - reset clears gains to zero, limits to 1.0, the window sums and the
//    ring pointer; the history ring reads as zero until filled once.
module windowed_integral_pid_3axis
	import wpid_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] prop_q, integ_q, deriv_q, limit_q;

	sample_t                 sample_s1;
	axis_term_t [AXES-1:0]   terms, terms_s2;
	logic                    v_s1, v_s2, v_s3;
	logic                    rdy_out, rdy_s3, rdy_s2;
	logic                    adv_s1, adv_s2, adv_s3;
	logic [AXES-1:0][DATA_W-1:0] drive;
	logic [AXES-1:0]         clip;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= '0;
			integ_q <= '0;
			deriv_q <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP:  prop_q  <= cfg_data;
				REG_INTEG: integ_q <= cfg_data;
				REG_DERIV: deriv_q <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data;
			endcase
		end
	end

	// stage handshakes, each stage moves when the next one is free or moving
	assign rdy_out      = !result_valid || result_ready;
	assign rdy_s3       = !v_s3 || rdy_out;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign sample_ready = !v_s1 || rdy_s2;
	assign adv_s1       = v_s1 && rdy_s2;
	assign adv_s2       = v_s2 && rdy_s3;
	assign adv_s3       = v_s3 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (sample_ready) v_s1 <= sample_valid;
			if (rdy_s2)       v_s2 <= v_s1;
			if (rdy_s3)       v_s3 <= v_s2;
			if (rdy_out)      result_valid <= v_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) sample_s1 <= sample;
	end

	// error and window stage
	wpid_window #(
		.WINDOW(WINDOW)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(adv_s1),
		.sample (sample_s1),
		.limits (limit_q),
		.terms  (terms)
	);

	always_ff @(posedge clk) begin
		if (adv_s1) terms_s2 <= terms;
	end

	// multiply and combine, one unit per axis
	for (genvar a = 0; a < AXES; a++) begin : g_axis
		wpid_axis_mac u_mac (
			.clk  (clk),
			.en   (adv_s2),
			.term (terms_s2[a]),
			.kp   ($signed(lane(prop_q, a))),
			.ki   ($signed(lane(integ_q, a))),
			.kd   ($signed(lane(deriv_q, a))),
			.drive(drive[a]),
			.clip (clip[a])
		);
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			result.drive_x <= drive[0];
			result.drive_y <= drive[1];
			result.drive_z <= drive[2];
			result.clipped <= clip;
		end
	end

	// ready drops only with every stage occupied
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (v_s1 && v_s2 && v_s3 && result_valid))
		else $error("sample_ready low with a free pipeline stage");

	// a new result always comes out of the product stage
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v_s3))
		else $error("result appeared without an item in the product stage");

	// a clipped x drive sits at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.clipped[0]) |->
			(result.drive_x == {1'b0, {(DATA_W-1){1'b1}}} ||
			 result.drive_x == {1'b1, {(DATA_W-1){1'b0}}}))
		else $error("clipped flag set on an unsaturated x drive");

endmodule

>>> hw/rtl/wpid_window.sv
// wpid_window: position error, sliding-window error sums and integral clamp.
// Holds the error history ring, running sums and ring pointer.
// Depends on wpid_pkg.
module wpid_window
	import wpid_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  sample_t                  sample,
	input  logic [CFG_W-1:0]         limits,
	output axis_term_t [AXES-1:0]    terms
);

	localparam int SUM_W  = DATA_W + 1 + $clog2(WINDOW);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	logic [AXES-1:0][DATA_W-1:0] tgt, meas, spd;
	logic [AXES-1:0][DATA_W-1:0] err_row, old_row;

	// history ring, one row holds all three axes
	logic [AXES-1:0][DATA_W-1:0] hist_mem [WINDOW];
	logic [AXES-1:0][DATA_W-1:0] rd_row_q, fwd_row_q;
	logic                        fwd_q;
	logic                        wrapped_q;
	logic [SLOT_W-1:0]           slot_q, slot_nxt, rd_addr;

	logic signed [SUM_W-1:0] sum_q   [AXES];
	logic signed [SUM_W-1:0] sum_nxt [AXES];
	logic signed [SUM_W-1:0] lim_ext [AXES];
	logic signed [SUM_W-1:0] lim_neg [AXES];
	logic signed [DATA_W:0]  diff    [AXES];

	assign tgt  = {sample.target_z, sample.target_y, sample.target_x};
	assign meas = {sample.meas_z, sample.meas_y, sample.meas_x};
	assign spd  = {sample.speed_z, sample.speed_y, sample.speed_x};

	// ring pointer and read address for the next item
	assign slot_nxt = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
	assign rd_addr  = advance ? slot_nxt : slot_q;

	// entry leaving the window, zero until the ring has been filled once
	assign old_row = !wrapped_q ? '0 : (fwd_q ? fwd_row_q : rd_row_q);

	// error, sum update and clamp per axis
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			diff[a] = {tgt[a][DATA_W-1], tgt[a]} - {meas[a][DATA_W-1], meas[a]};
			if (diff[a][DATA_W] != diff[a][DATA_W-1]) begin
				err_row[a] = diff[a][DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
					: {1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				err_row[a] = diff[a][DATA_W-1:0];
			end
			sum_nxt[a] = sum_q[a]
				- {{(SUM_W-DATA_W){old_row[a][DATA_W-1]}}, old_row[a]}
				+ {{(SUM_W-DATA_W){err_row[a][DATA_W-1]}}, err_row[a]};
			lim_ext[a] = {{(SUM_W-LIM_W){1'b0}}, lane(limits, a), 8'h00};
			lim_neg[a] = -lim_ext[a];
			terms[a].err = err_row[a];
			terms[a].vel = spd[a];
			if (sum_nxt[a] > lim_ext[a]) begin
				terms[a].integ = lim_ext[a][INTEG_W-1:0];
			end else if (sum_nxt[a] < lim_neg[a]) begin
				terms[a].integ = lim_neg[a][INTEG_W-1:0];
			end else begin
				terms[a].integ = sum_nxt[a][INTEG_W-1:0];
			end
		end
	end

	// running sums, pointer and fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) sum_q[a] <= '0;
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			fwd_q     <= 1'b0;
		end else begin
			fwd_q <= advance && (slot_q == rd_addr);
			if (advance) begin
				for (int a = 0; a < AXES; a++) sum_q[a] <= sum_nxt[a];
				slot_q <= slot_nxt;
				if (slot_q == LAST_SLOT) wrapped_q <= 1'b1;
			end
		end
	end

	// history memory with registered read and write-through bypass
	always_ff @(posedge clk) begin
		if (advance) hist_mem[slot_q] <= err_row;
		rd_row_q  <= hist_mem[rd_addr];
		fwd_row_q <= err_row;
	end

endmodule

>>> hw/rtl/wpid_axis_mac.sv
// wpid_axis_mac: one axis of gain multiplies, then sum, rounding and saturation.
// Products are registered; the drive is formed from the product registers.
// Depends on wpid_pkg.
module wpid_axis_mac
	import wpid_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  axis_term_t               term,
	input  logic signed [GAIN_W-1:0] kp,
	input  logic signed [GAIN_W-1:0] ki,
	input  logic signed [GAIN_W-1:0] kd,
	output logic signed [DATA_W-1:0] drive,
	output logic                     clip
);

	logic signed [PROD_W-1:0]  prod_p, prod_d, prod_p_s3, prod_d_s3;
	logic signed [PRODI_W-1:0] prod_i, prod_i_s3;
	logic signed [ACC_W-1:0]   acc, acc_r;
	logic signed [RND_W-1:0]   rnd;
	logic [RND_W-DATA_W:0]     top_bits;

	// gain multiplies
	assign prod_p = kp * term.err;
	assign prod_i = ki * term.integ;
	assign prod_d = kd * term.vel;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			prod_d_s3 <= prod_d;
		end
	end

	// q26.24 total, round half up to q16.16
	assign acc = {{(ACC_W-PROD_W){prod_p_s3[PROD_W-1]}}, prod_p_s3}
		+ {{(ACC_W-PRODI_W){prod_i_s3[PRODI_W-1]}}, prod_i_s3}
		- {{(ACC_W-PROD_W){prod_d_s3[PROD_W-1]}}, prod_d_s3};
	assign acc_r    = acc + ACC_W'(128);
	assign rnd      = acc_r[ACC_W-1:8];
	assign top_bits = rnd[RND_W-1:DATA_W-1];

	// saturate to 32 bits
	always_comb begin
		if (top_bits == '0 || top_bits == '1) begin
			drive = rnd[DATA_W-1:0];
			clip  = 1'b0;
		end else begin
			drive = rnd[RND_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
			clip  = 1'b1;
		end
	end

endmodule
